// ===== sv/tuvm_pkg.sv =====
// tuvm_pkg: shared types, constants and the arctangent table for the uv mapper
// used by every file of the texture uv mapper; depends on nothing
package tuvm_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int TEX_W   = 18;
  localparam int MODE_W  = 2;

  // internal widths: cordic vector/angle, squared sum, square root result
  localparam int CW      = 36;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 33;
  localparam int SQ_STEPS = 32;

  localparam int ANGLE_STAGES_DEF = 18;
  localparam int ANGLE_STAGES_MAX = 32;

  // mapping modes
  localparam logic [MODE_W-1:0] MODE_PLANAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPH    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CYL    = 2'd2;

  // pi in Q2.30 and 2^32/pi
  localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic [63:0] INV_PI_Q32 = 64'd1367130551;

  // rounding shifts for u (angle sum over 2pi) and v (angle over pi)
  localparam int U_SHIFT = 47;
  localparam int V_SHIFT = 46;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cvec_t;

  // point carried through the square root chain
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pt_t;

  // per-word flags and ready-made results carried through the cordic chain
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic                    status;
    logic                    zero_a;
    logic                    zero_b;
    logic signed [TEX_W-1:0] pre_u;
    logic signed [TEX_W-1:0] pre_v;
  } side_t;

  typedef struct packed {
    cvec_t a;
    cvec_t b;
    side_t side;
  } cstate_t;

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h3243F6A8;
      1:  t = 32'h1DAC6705;
      2:  t = 32'h0FADBAFC;
      3:  t = 32'h07F56EA6;
      4:  t = 32'h03FEAB76;
      5:  t = 32'h01FFD55B;
      6:  t = 32'h00FFFAAA;
      7:  t = 32'h007FFF55;
      8:  t = 32'h003FFFEA;
      9:  t = 32'h001FFFFD;
      10: t = 32'h000FFFFF;
      11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF;
      13: t = 32'h0001FFFF;
      14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF;
      16: t = 32'h00003FFF;
      17: t = 32'h00001FFF;
      18: t = 32'h00000FFF;
      19: t = 32'h000007FF;
      20: t = 32'h000003FF;
      21: t = 32'h000001FF;
      22: t = 32'h000000FF;
      23: t = 32'h0000007F;
      24: t = 32'h0000003F;
      25: t = 32'h0000001F;
      26: t = 32'h0000000F;
      27: t = 32'h00000008;
      28: t = 32'h00000004;
      29: t = 32'h00000002;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/tuvm_in_if.sv =====
// tuvm_in_if: input channel carrying one hit point word
// depends on tuvm_pkg
interface tuvm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [tuvm_pkg::MODE_W-1:0]           req_type;
  logic signed [tuvm_pkg::COORD_W-1:0]   coord_x;
  logic signed [tuvm_pkg::COORD_W-1:0]   coord_y;
  logic signed [tuvm_pkg::COORD_W-1:0]   coord_z;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

// ===== sv/tuvm_out_if.sv =====
// tuvm_out_if: output channel carrying one texture coordinate word
// depends on tuvm_pkg
interface tuvm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tuvm_pkg::TEX_W-1:0]   tex_u;
  logic signed [tuvm_pkg::TEX_W-1:0]   tex_v;
  logic                                map_status;

  modport source (output valid, tex_u, tex_v, map_status, input ready);
  modport sink   (input valid, tex_u, tex_v, map_status, output ready);
endinterface

// ===== sv/tuvm_sqrt_cell.sv =====
// tuvm_sqrt_cell: one step of the bit-pair integer square root, with its own word register
// depends on tuvm_pkg
module tuvm_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tuvm_pkg::SUM_W-1:0]   in_rem,
  input  logic [tuvm_pkg::SUM_W-1:0]   in_res,
  input  tuvm_pkg::pt_t                in_pt,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tuvm_pkg::SUM_W-1:0]   out_rem,
  output logic [tuvm_pkg::SUM_W-1:0]   out_res,
  output tuvm_pkg::pt_t                out_pt
);

  localparam logic [tuvm_pkg::SUM_W-1:0] BIT =
    tuvm_pkg::SUM_W'(1) << (tuvm_pkg::SUM_W - 2 - 2 * STEP);

  logic [tuvm_pkg::SUM_W-1:0] trial;
  logic [tuvm_pkg::SUM_W-1:0] rem_next;
  logic [tuvm_pkg::SUM_W-1:0] res_next;

  // trial subtract of res + bit
  always_comb begin
    trial = in_res + BIT;
    if (in_rem >= trial) begin
      rem_next = in_rem - trial;
      res_next = (in_res >> 1) + BIT;
    end else begin
      rem_next = in_rem;
      res_next = in_res >> 1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem <= rem_next;
      out_res <= res_next;
      out_pt  <= in_pt;
    end
  end

endmodule

// ===== sv/tuvm_cordic_cell.sv =====
// tuvm_cordic_cell: one vectoring cordic stage applied to both angle lanes
// depends on tuvm_pkg
module tuvm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tuvm_pkg::cstate_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tuvm_pkg::cstate_t out_data
);

  localparam logic signed [tuvm_pkg::CW-1:0] ANG =
    tuvm_pkg::CW'(tuvm_pkg::atan_q30(STAGE));

  // rotate toward the x axis, floor shifts
  function automatic tuvm_pkg::cvec_t rot(input tuvm_pkg::cvec_t v);
    tuvm_pkg::cvec_t r;
    logic signed [tuvm_pkg::CW-1:0] dx;
    logic signed [tuvm_pkg::CW-1:0] dy;
    dx = v.y >>> STAGE;
    dy = v.x >>> STAGE;
    if (v.y > 0) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + ANG;
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - ANG;
    end
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  // stage handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.a    <= rot(in_data.a);
      out_data.b    <= rot(in_data.b);
      out_data.side <= in_data.side;
    end
  end

endmodule

// ===== sv/texture_uv_mapper_core.sv =====
// texture_uv_mapper_core: top level of the planar, spherical and cylindrical uv mapper
// depends on tuvm_pkg, tuvm_in_if, tuvm_out_if, tuvm_sqrt_cell, tuvm_cordic_cell
//
// usage
// - in_ch takes one hit point word (req_type, coord_x/y/z in Q16.16) when
//   valid and ready are both high; out_ch gives tex_u, tex_v (Q1.16) and
//   map_status for every word, in order.
// - a new word can be taken every cycle while out_ch is not stalled; throughput is one word per cycle.
// - from acceptance to out_ch.valid a word passes the input register, a
//   squaring and a summing stage, 32 square root cells, a setup stage,
//   ANGLE_STAGES cordic cells, a clamp and a multiply stage, and the
//   output register, which takes the rounded result.
// - every stage has its own valid bit and takes a word when it is empty or
//   its word moves on, so idle stages fill up when out_ch stalls and
//   in_ch.ready drops only once the whole chain is full.
// - rst (synchronous) empties every stage; no word survives reset.
// - planar words finish through the same chain as the others.
module texture_uv_mapper_core #(
  parameter int ANGLE_STAGES = tuvm_pkg::ANGLE_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  tuvm_in_if.sink          in_ch,
  tuvm_out_if.source       out_ch
);

  localparam int NSQ = tuvm_pkg::SQ_STEPS;
  localparam int CW  = tuvm_pkg::CW;

  // load point into a cordic lane, folding the left half plane
  function automatic tuvm_pkg::cvec_t prep(input logic signed [CW-1:0] b,
                                           input logic signed [CW-1:0] a);
    tuvm_pkg::cvec_t r;
    if (a < 0) begin
      r.x = -a;
      r.y = -b;
      r.z = (b >= 0) ? tuvm_pkg::PI_Q30 : -tuvm_pkg::PI_Q30;
    end else begin
      r.x = a;
      r.y = b;
      r.z = '0;
    end
    return r;
  endfunction

  // truncated fraction keeping the sign of the coordinate
  function automatic logic signed [tuvm_pkg::TEX_W-1:0] tfrac(
      input logic signed [tuvm_pkg::COORD_W-1:0] c);
    logic signed [tuvm_pkg::COORD_W:0] m;
    logic signed [tuvm_pkg::TEX_W-1:0] f;
    if (c >= 0) begin
      f = tuvm_pkg::TEX_W'({2'b00, c[15:0]});
    end else begin
      m = -(tuvm_pkg::COORD_W + 1)'(c);
      f = -tuvm_pkg::TEX_W'({2'b00, m[15:0]});
    end
    return f;
  endfunction

  // input register
  logic          v1;
  logic          rdy1;
  tuvm_pkg::pt_t pt1;

  // squares
  logic                          v2;
  logic                          rdy2;
  tuvm_pkg::pt_t                 pt2;
  logic [tuvm_pkg::SUM_W-1:0]    xx2;
  logic [tuvm_pkg::SUM_W-1:0]    zz2;

  // sum of squares
  logic                          v3;
  logic                          rdy3;
  tuvm_pkg::pt_t                 pt3;
  logic [tuvm_pkg::SUM_W-1:0]    sum3;

  // square root chain
  logic                          sq_v   [0:NSQ];
  logic                          sq_rdy [0:NSQ];
  logic [tuvm_pkg::SUM_W-1:0]    sq_rem [0:NSQ];
  logic [tuvm_pkg::SUM_W-1:0]    sq_res [0:NSQ];
  tuvm_pkg::pt_t                 sq_pt  [0:NSQ];

  // cordic chain, entry 0 is the setup register
  logic                          co_v   [0:ANGLE_STAGES];
  logic                          co_rdy [0:ANGLE_STAGES];
  tuvm_pkg::cstate_t             co_d   [0:ANGLE_STAGES];
  tuvm_pkg::cstate_t             su_next;

  // clamp stage
  logic                          vp;
  logic                          rdyp;
  tuvm_pkg::side_t               sidep;
  logic [33:0]                   wu;
  logic [33:0]                   wv;
  logic [33:0]                   wu_next;
  logic [33:0]                   wv_next;

  // multiply stage
  logic                          vm;
  logic                          rdym;
  tuvm_pkg::side_t               sidem;
  logic [63:0]                   pu;
  logic [63:0]                   pv;

  // output register
  logic                          rdyo;
  logic signed [tuvm_pkg::TEX_W-1:0] u_next;
  logic signed [tuvm_pkg::TEX_W-1:0] v_next;
  logic                          st_next;
  logic [63:0]                   ur;
  logic [63:0]                   vr;

  assign rdy1 = !v1 || rdy2;
  assign rdy2 = !v2 || rdy3;
  assign rdy3 = !v3 || sq_rdy[0];
  assign in_ch.ready = rdy1;

  // front stages handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_ch.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // front stages data
  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      pt1.mode <= in_ch.req_type;
      pt1.x    <= in_ch.coord_x;
      pt1.y    <= in_ch.coord_y;
      pt1.z    <= in_ch.coord_z;
    end
    if (rdy2 && v1) begin
      pt2 <= pt1;
      xx2 <= tuvm_pkg::SUM_W'(pt1.x) * tuvm_pkg::SUM_W'(pt1.x);
      zz2 <= tuvm_pkg::SUM_W'(pt1.z) * tuvm_pkg::SUM_W'(pt1.z);
    end
    if (rdy3 && v2) begin
      pt3  <= pt2;
      sum3 <= xx2 + zz2;
    end
  end

  assign sq_v[0]   = v3;
  assign sq_rem[0] = sum3;
  assign sq_res[0] = '0;
  assign sq_pt[0]  = pt3;

  // square root cells
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    tuvm_sqrt_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_rem    (sq_rem[k]),
      .in_res    (sq_res[k]),
      .in_pt     (sq_pt[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_res   (sq_res[k+1]),
      .out_pt    (sq_pt[k+1])
    );
  end

  // setup: pick lane operands, zero checks, early results
  always_comb begin
    tuvm_pkg::pt_t p;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] ar;
    p  = sq_pt[NSQ];
    ax = CW'(p.x);
    ay = CW'(p.y);
    az = CW'(p.z);
    ar = CW'({1'b0, sq_res[NSQ][tuvm_pkg::ROOT_W-1:0]});
    if (p.mode == tuvm_pkg::MODE_CYL) begin
      su_next.a           = prep(ax, az);
      su_next.side.zero_a = (ax == 0) && (az == 0);
    end else begin
      su_next.a           = prep(az, ax);
      su_next.side.zero_a = (ax == 0) && (az == 0);
    end
    su_next.b           = prep(ar, ay);
    su_next.side.zero_b = (ar == 0) && (ay == 0);
    su_next.side.mode   = p.mode;
    su_next.side.status = (p.mode == tuvm_pkg::MODE_SPH) &&
                          (p.x == 0) && (p.y == 0) && (p.z == 0);
    if (p.mode == tuvm_pkg::MODE_PLANAR) begin
      su_next.side.pre_u = tfrac(p.x);
      su_next.side.pre_v = tfrac(p.z);
    end else begin
      su_next.side.pre_u = '0;
      su_next.side.pre_v = tuvm_pkg::TEX_W'({2'b00, p.y[15:0]});
    end
  end

  assign sq_rdy[NSQ] = !co_v[0] || co_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      co_v[0] <= 1'b0;
    end else if (sq_rdy[NSQ]) begin
      co_v[0] <= sq_v[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy[NSQ] && sq_v[NSQ]) begin
      co_d[0] <= su_next;
    end
  end

  // cordic cells
  for (genvar s = 0; s < ANGLE_STAGES; s++) begin : g_co
    tuvm_cordic_cell #(.STAGE(s)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (co_v[s]),
      .in_ready  (co_rdy[s]),
      .in_data   (co_d[s]),
      .out_valid (co_v[s+1]),
      .out_ready (co_rdy[s+1]),
      .out_data  (co_d[s+1])
    );
  end

  // clamp angles and form the sums to scale
  always_comb begin
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] pol;
    logic signed [CW-1:0] su;
    az  = co_d[ANGLE_STAGES].side.zero_a ? '0 : co_d[ANGLE_STAGES].a.z;
    pol = co_d[ANGLE_STAGES].side.zero_b ? '0 : co_d[ANGLE_STAGES].b.z;
    if (az > tuvm_pkg::PI_Q30) az = tuvm_pkg::PI_Q30;
    if (az < -tuvm_pkg::PI_Q30) az = -tuvm_pkg::PI_Q30;
    if (pol > tuvm_pkg::PI_Q30) pol = tuvm_pkg::PI_Q30;
    if (pol < 0) pol = '0;
    if (co_d[ANGLE_STAGES].side.mode == tuvm_pkg::MODE_CYL) begin
      su = tuvm_pkg::PI_Q30 - az;
    end else begin
      su = tuvm_pkg::PI_Q30 + az;
    end
    wu_next = su[33:0];
    wv_next = pol[33:0];
  end

  assign co_rdy[ANGLE_STAGES] = !vp || rdyp;
  assign rdyp = !vm || rdym;
  assign rdym = !out_ch.valid || rdyo;
  assign rdyo = out_ch.ready;

  // back stages handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      vp           <= 1'b0;
      vm           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (co_rdy[ANGLE_STAGES]) vp <= co_v[ANGLE_STAGES];
      if (rdyp) vm <= vp;
      if (rdym) out_ch.valid <= vm;
    end
  end

  // rounding and result select
  always_comb begin
    ur = (pu + (64'd1 << (tuvm_pkg::U_SHIFT - 1))) >> tuvm_pkg::U_SHIFT;
    vr = (pv + (64'd1 << (tuvm_pkg::V_SHIFT - 1))) >> tuvm_pkg::V_SHIFT;
    st_next = 1'b0;
    case (sidem.mode)
      tuvm_pkg::MODE_PLANAR: begin
        u_next = sidem.pre_u;
        v_next = sidem.pre_v;
      end
      tuvm_pkg::MODE_SPH: begin
        st_next = sidem.status;
        u_next  = sidem.status ? '0 : ur[tuvm_pkg::TEX_W-1:0];
        v_next  = sidem.status ? '0 : vr[tuvm_pkg::TEX_W-1:0];
      end
      tuvm_pkg::MODE_CYL: begin
        u_next = ur[tuvm_pkg::TEX_W-1:0];
        v_next = sidem.pre_v;
      end
      default: begin
        u_next = '0;
        v_next = '0;
      end
    endcase
  end

  // back stages data
  always_ff @(posedge clk) begin
    if (co_rdy[ANGLE_STAGES] && co_v[ANGLE_STAGES]) begin
      sidep <= co_d[ANGLE_STAGES].side;
      wu    <= wu_next;
      wv    <= wv_next;
    end
    if (rdyp && vp) begin
      sidem <= sidep;
      pu    <= 64'(wu) * tuvm_pkg::INV_PI_Q32;
      pv    <= 64'(wv) * tuvm_pkg::INV_PI_Q32;
    end
    if (rdym && vm) begin
      out_ch.tex_u      <= u_next;
      out_ch.tex_v      <= v_next;
      out_ch.map_status <= st_next;
    end
  end

endmodule

// ===== sv/tuvm_checker.sv =====
// tuvm_checker: port-level checks on the uv mapper output, bound to the top level
// depends on tuvm_pkg, texture_uv_mapper_core
module tuvm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tuvm_pkg::TEX_W-1:0]   tex_u,
  input logic signed [tuvm_pkg::TEX_W-1:0]   tex_v,
  input logic                                map_status
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tex_u) && $stable(tex_v))
    else $error("stalled output word changed");

  // error status comes with zero coordinates
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_status |-> tex_u == 0 && tex_v == 0)
    else $error("status set with nonzero coordinates");

  // coordinates stay within one unit
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_u <= 18'sd65536 && tex_u >= -18'sd65536 &&
                  tex_v <= 18'sd65536 && tex_v >= -18'sd65536)
    else $error("coordinate out of range");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind texture_uv_mapper_core tuvm_checker u_tuvm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .tex_u      (out_ch.tex_u),
  .tex_v      (out_ch.tex_v),
  .map_status (out_ch.map_status)
);
